// File: rtl/gha_pkg.sv
// Package for the generational handle allocator: sizes, request and status codes,
// and the slot entry layout. No dependencies.
package gha_pkg;

  localparam int NUM_SLOTS = 256;
  localparam int SLOT_W    = 8;
  localparam int CNT_W     = 9;
  localparam int ID_W      = 64;
  localparam int GEN_W     = 32;
  // slot entry: {live, generation, owner id}
  localparam int ENTRY_W   = 1 + GEN_W + ID_W;

  // Request codes
  localparam logic [2:0] REQ_ACTIVATE = 3'd0;
  localparam logic [2:0] REQ_DESTROY  = 3'd1;
  localparam logic [2:0] REQ_CHECK    = 3'd2;
  localparam logic [2:0] REQ_FIND     = 3'd3;
  localparam logic [2:0] REQ_GET      = 3'd4;
  localparam logic [2:0] REQ_CLEAR    = 3'd5;

  // Status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_INVALID  = 3'd1;
  localparam logic [2:0] ST_DUP      = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  // Generation increment that skips zero on wrap
  function automatic logic [GEN_W-1:0] gen_inc(input logic [GEN_W-1:0] g);
    logic [GEN_W-1:0] n;
    n = g + 1'b1;
    return (n == '0) ? {{(GEN_W-1){1'b0}}, 1'b1} : n;
  endfunction

endpackage

// File: rtl/gha_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gha_ram #(
  parameter int W = 8,
  parameter int D = 256
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/gha_slot_flags.sv
// Slot entry fields {live, generation, owner id} as held in the slot RAM, and the
// entry written back when a slot is freed. Depends on gha_pkg.
module gha_slot_flags (
  input  logic [gha_pkg::ENTRY_W-1:0] entry,
  output logic                        live,
  output logic [gha_pkg::GEN_W-1:0]   gen,
  output logic [gha_pkg::ID_W-1:0]    owner,
  output logic [gha_pkg::ENTRY_W-1:0] released
);
  import gha_pkg::*;

  assign live  = entry[ENTRY_W-1];
  assign gen   = entry[ID_W +: GEN_W];
  assign owner = entry[ID_W-1:0];

  // freeing drops the live flag and bumps the generation
  assign released = {1'b0, gen_inc(gen), owner};

endmodule

// File: rtl/generational_handle_allocator.sv
// Generational handle allocator: 256-slot map of world ids to (slot, generation).
// One request at a time: in_tready is high only in idle, and a result waiting on out_tready
// holds the next request.
// Search and clear walk the slot RAM one entry per cycle through its single read port.
// Reset: synchronous, active low; clears state, counters and output valid only, entries at or above high water unread.
module generational_handle_allocator (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [111:0] in_tdata,  // object_id[63:0], handle_slot[79:64], handle_gen[111:80]
  input  logic [2:0]   in_tuser,  // req_type[2:0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [119:0] out_tdata, // out_slot[7:0], out_gen[39:8], out_object_id[103:40],
                                  // live_count[112:104], zero fill above
  output logic [2:0]   out_tuser  // status[2:0]
);
  import gha_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_POP, S_RDGEN, S_HCHK, S_CLEAR, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic [2:0]        req_r, req_nxt;
  logic [ID_W-1:0]   oid_r, oid_nxt;
  logic [15:0]       hs_r, hs_nxt;
  logic [GEN_W-1:0]  hg_r, hg_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              pend_r, pend_nxt;
  logic [SLOT_W-1:0] pidx_r, pidx_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic              fresh_r, fresh_nxt;
  logic [CNT_W-1:0]  hw_r, hw_nxt;
  logic [CNT_W-1:0]  fd_r, fd_nxt;
  logic [2:0]        res_st_r, res_st_nxt;
  logic [SLOT_W-1:0] res_slot_r, res_slot_nxt;
  logic [GEN_W-1:0]  res_gen_r, res_gen_nxt;
  logic [ID_W-1:0]   res_obj_r, res_obj_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [119:0]      out_data_r, out_data_nxt;
  logic [2:0]        out_user_r, out_user_nxt;

  logic              m_we;
  logic [SLOT_W-1:0] m_waddr, m_raddr;
  logic [ENTRY_W-1:0] m_wdata, m_rdata;
  logic              f_we;
  logic [SLOT_W-1:0] f_waddr, f_raddr, f_wdata, f_rdata;

  logic [ID_W-1:0]   in_oid;
  logic [15:0]       in_hs;
  logic [GEN_W-1:0]  in_hg;
  logic              e_live;
  logic [GEN_W-1:0]  e_gen;
  logic [ID_W-1:0]   e_owner;
  logic [ENTRY_W-1:0] e_rel;
  logic [GEN_W-1:0]  bind_gen;
  logic              hit, scan_done;
  logic [CNT_W-1:0]  live_cnt;

  assign in_oid   = in_tdata[63:0];
  assign in_hs    = in_tdata[79:64];
  assign in_hg    = in_tdata[111:80];
  // a slot taken from high water was never written and starts at generation one
  assign bind_gen  = fresh_r ? {{(GEN_W-1){1'b0}}, 1'b1} : e_gen;
  assign hit       = pend_r && e_live && (e_owner == oid_r);
  assign scan_done = !pend_r && (cnt_r >= hw_r);
  assign live_cnt  = hw_r - fd_r;

  // slot table: {live, generation, owner id}
  gha_ram #(.W(ENTRY_W), .D(NUM_SLOTS)) u_slot_ram (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
    .raddr(m_raddr), .rdata(m_rdata)
  );

  // LIFO of freed slots
  gha_ram #(.W(SLOT_W), .D(NUM_SLOTS)) u_free_ram (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
    .raddr(f_raddr), .rdata(f_rdata)
  );

  gha_slot_flags u_flags (
    .entry(m_rdata), .live(e_live), .gen(e_gen), .owner(e_owner), .released(e_rel)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    req_nxt      = req_r;
    oid_nxt      = oid_r;
    hs_nxt       = hs_r;
    hg_nxt       = hg_r;
    cnt_nxt      = cnt_r;
    pend_nxt     = pend_r;
    pidx_nxt     = pidx_r;
    slot_nxt     = slot_r;
    fresh_nxt    = fresh_r;
    hw_nxt       = hw_r;
    fd_nxt       = fd_r;
    res_st_nxt   = res_st_r;
    res_slot_nxt = res_slot_r;
    res_gen_nxt  = res_gen_r;
    res_obj_nxt  = res_obj_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt = out_data_r;
    out_user_nxt = out_user_r;
    m_we    = 1'b0;
    m_waddr = '0;
    m_wdata = '0;
    m_raddr = '0;
    f_we    = 1'b0;
    f_waddr = fd_r[SLOT_W-1:0];
    f_wdata = '0;
    f_raddr = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          req_nxt      = in_tuser;
          oid_nxt      = in_oid;
          hs_nxt       = in_hs;
          hg_nxt       = in_hg;
          cnt_nxt      = '0;
          pend_nxt     = 1'b0;
          res_st_nxt   = ST_INVALID;
          res_slot_nxt = '0;
          res_gen_nxt  = '0;
          res_obj_nxt  = '0;
          state_nxt    = S_OUT;
          case (in_tuser)
            REQ_ACTIVATE, REQ_FIND: begin
              if (in_oid != '0) begin
                state_nxt = S_SCAN;
              end else if (in_tuser == REQ_FIND) begin
                res_st_nxt = ST_NOTFOUND;
              end
            end
            REQ_DESTROY, REQ_CHECK, REQ_GET: begin
              // cheap checks first, live and generation after the RAM read
              if (in_hg != '0 && {{(16-CNT_W){1'b0}}, hw_r} > in_hs) begin
                m_raddr   = in_hs[SLOT_W-1:0];
                state_nxt = S_HCHK;
              end
            end
            REQ_CLEAR: state_nxt = S_CLEAR;
            default: ;
          endcase
        end
      end

      S_SCAN: begin
        if (hit) begin
          if (req_r == REQ_ACTIVATE) begin
            res_st_nxt = ST_DUP;
          end else begin
            res_st_nxt   = ST_OK;
            res_slot_nxt = pidx_r;
            res_gen_nxt  = e_gen;
          end
          state_nxt = S_OUT;
        end else if (scan_done) begin
          if (req_r == REQ_FIND) begin
            res_st_nxt = ST_NOTFOUND;
            state_nxt  = S_OUT;
          end else if (fd_r != '0) begin
            f_raddr   = fd_r[SLOT_W-1:0] - 1'b1;
            fd_nxt    = fd_r - 1'b1;
            fresh_nxt = 1'b0;
            state_nxt = S_POP;
          end else if (hw_r < CNT_W'(NUM_SLOTS)) begin
            slot_nxt  = hw_r[SLOT_W-1:0];
            m_raddr   = hw_r[SLOT_W-1:0];
            hw_nxt    = hw_r + 1'b1;
            fresh_nxt = 1'b1;
            state_nxt = S_RDGEN;
          end else begin
            res_st_nxt = ST_FULL;
            state_nxt  = S_OUT;
          end
        end else begin
          m_raddr  = cnt_r[SLOT_W-1:0];
          pend_nxt = (cnt_r < hw_r);
          pidx_nxt = cnt_r[SLOT_W-1:0];
          if (cnt_r < hw_r) begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end

      S_POP: begin
        slot_nxt  = f_rdata;
        m_raddr   = f_rdata;
        state_nxt = S_RDGEN;
      end

      S_RDGEN: begin
        // bind the slot to the id
        m_we          = 1'b1;
        m_waddr       = slot_r;
        m_wdata       = {1'b1, bind_gen, oid_r};
        res_st_nxt    = ST_OK;
        res_slot_nxt  = slot_r;
        res_gen_nxt   = bind_gen;
        state_nxt     = S_OUT;
      end

      S_HCHK: begin
        if (e_live && e_gen == hg_r) begin
          res_st_nxt = ST_OK;
          if (req_r == REQ_GET) begin
            res_obj_nxt = e_owner;
          end else if (req_r == REQ_DESTROY) begin
            m_we    = 1'b1;
            m_waddr = hs_r[SLOT_W-1:0];
            m_wdata = e_rel;
            if (fd_r < CNT_W'(NUM_SLOTS)) begin
              f_we    = 1'b1;
              f_wdata = hs_r[SLOT_W-1:0];
              fd_nxt  = fd_r + 1'b1;
            end
          end
        end
        state_nxt = S_OUT;
      end

      S_CLEAR: begin
        // release the slot read last cycle while issuing the next read
        if (pend_r && e_live) begin
          m_we    = 1'b1;
          m_waddr = pidx_r;
          m_wdata = e_rel;
          if (fd_r < CNT_W'(NUM_SLOTS)) begin
            f_we    = 1'b1;
            f_wdata = pidx_r;
            fd_nxt  = fd_r + 1'b1;
          end
        end
        if (scan_done) begin
          res_st_nxt = ST_OK;
          state_nxt  = S_OUT;
        end else begin
          m_raddr  = cnt_r[SLOT_W-1:0];
          pend_nxt = (cnt_r < hw_r);
          pidx_nxt = cnt_r[SLOT_W-1:0];
          if (cnt_r < hw_r) begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end

      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_user_nxt  = res_st_r;
          out_data_nxt  = {7'd0, live_cnt, res_obj_r, res_gen_r, res_slot_r};
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      hw_r        <= '0;
      fd_r        <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hw_r        <= hw_nxt;
      fd_r        <= fd_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and datapath registers
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    oid_r      <= oid_nxt;
    hs_r       <= hs_nxt;
    hg_r       <= hg_nxt;
    cnt_r      <= cnt_nxt;
    pidx_r     <= pidx_nxt;
    slot_r     <= slot_nxt;
    fresh_r    <= fresh_nxt;
    res_st_r   <= res_st_nxt;
    res_slot_r <= res_slot_nxt;
    res_gen_r  <= res_gen_nxt;
    res_obj_r  <= res_obj_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

`ifndef SYNTH
  // free list never holds more slots than were ever handed out
  a_fd_le_hw: assert property (@(posedge clk) disable iff (!rst_n) fd_r <= hw_r)
    else $error("free depth above high water");

  // high water only grows
  a_hw_mono: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> hw_r >= $past(hw_r))
    else $error("high water decreased");

  // failed requests return no handle
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_user_r != ST_OK |-> out_data_r[103:0] == '0)
    else $error("non-zero payload on failed request");
`endif

endmodule
